// ----- hw/rtl/gfo_pkg.sv -----
// ----------------------------------------------------------------------------
// gfo_pkg
// Shared constants, the arctangent table and helpers for the field
// orientation pipeline.
// ----------------------------------------------------------------------------
package gfo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 32;

  localparam logic signed [31:0] PI_Q24      = 32'sd52707179;
  localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;
  localparam logic signed [31:0] GAIN_Q24    = 32'sd10188014;
  localparam logic signed [19:0] PI_Q13      = 20'sd25736;
  localparam logic signed [19:0] TWO_PI_Q13  = 20'sd51472;
  localparam logic signed [20:0] PITCH_LIMIT = 21'sd12868;

  // Register indexes on the configuration port
  localparam logic REG_YAW_OFFSET   = 1'b0;
  localparam logic REG_PITCH_OFFSET = 1'b1;

  // Pipeline stage positions
  localparam int ST_SINCOS = 25;
  localparam int ST_PROD   = 26;
  localparam int ST_MIX    = 27;
  localparam int ST_SQUARE = 28;
  localparam int ST_SUM    = 29;
  localparam int ST_SQRT   = ST_SUM + SQRT_STEPS;
  localparam int ST_ATAN   = ST_SQRT + CORDIC_STEPS;
  localparam int ST_OUT    = ST_ATAN + 1;

  typedef struct packed {
    logic signed [15:0] gp;
    logic signed [15:0] fy;
    logic signed [15:0] acc;
    logic signed [31:0] num;
    logic               zero;
  } side_t;

  function automatic logic signed [31:0] atan_q24(input int i);
    logic signed [31:0] v;
    case (i)
      0: v = 32'sd13176795;
      1: v = 32'sd7778716;
      2: v = 32'sd4110060;
      3: v = 32'sd2086331;
      4: v = 32'sd1047214;
      5: v = 32'sd524117;
      6: v = 32'sd262123;
      7: v = 32'sd131069;
      default: v = (i < 24) ? (32'sd1 <<< (24 - i)) : 32'sd0;
    endcase
    return v;
  endfunction

  // Reduce into [-pi, pi) for sums within a few periods
  function automatic logic signed [15:0] wrap_q13(input logic signed [18:0] v);
    logic signed [19:0] mid;
    logic signed [19:0] lo2;
    logic signed [19:0] lo1;
    logic signed [19:0] hi1;
    logic signed [19:0] hi2;
    logic signed [19:0] o;
    mid = 20'(v);
    lo2 = mid + (TWO_PI_Q13 + TWO_PI_Q13);
    lo1 = mid + TWO_PI_Q13;
    hi1 = mid - TWO_PI_Q13;
    hi2 = mid - (TWO_PI_Q13 + TWO_PI_Q13);
    // Pick the one candidate that lands in range
    if (mid < -PI_Q13 - TWO_PI_Q13) o = lo2;
    else if (mid < -PI_Q13) o = lo1;
    else if (mid < PI_Q13) o = mid;
    else if (mid < PI_Q13 + TWO_PI_Q13) o = hi1;
    else o = hi2;
    return o[15:0];
  endfunction

endpackage

// ----- hw/rtl/gimbal_field_orientation_core.sv -----
// ----------------------------------------------------------------------------
// gimbal_field_orientation_core
// Field-relative gimbal yaw and pitch, chassis pitch along the gimbal and
// acceleration along the gimbal, one sample per cycle while no result is stalled.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake
//  ---------+-----------+------------------------------------------
//  in       | input     | in_valid / in_stall, seven sample fields
//  out      | output    | out_valid / out_stall, four result fields
//  apb      | input     | psel/penable/pwrite, two offset registers
//
//  The pipeline has 25 sine/cosine CORDIC stages, four product stages,
//  32 square root stages, 24 atan2 stages and the output register.
//  One sample enters per cycle while no result is stalled. rst clears the valid bits and offsets.
//  A stalled result holds the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gimbal_field_orientation_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] gimbal_yaw_angle,
  input  logic signed [15:0] gimbal_pitch_angle,
  input  logic signed [15:0] chassis_yaw_angle,
  input  logic signed [15:0] chassis_roll_angle,
  input  logic signed [15:0] chassis_pitch_angle,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] field_yaw,
  output logic signed [15:0] field_pitch,
  output logic signed [14:0] chassis_pitch_along_gimbal,
  output logic signed [15:0] accel_along_gimbal,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import gfo_pkg::*;

  logic                en;
  logic [ST_OUT:1]     vld;
  logic signed [15:0]  yaw_offset;
  logic signed [15:0]  pitch_offset;
  gfo_pkg::side_t      side [1:ST_ATAN];

  logic signed [31:0]  sgy, cgy, scr, ccr, scp, ccp;
  logic signed [63:0]  m1, m2, m3, m4, m5, m6;
  logic signed [63:0]  num_full, acc_full;
  logic signed [63:0]  a_full, b_full;
  logic signed [31:0]  a_q, b_q;
  logic [63:0]         aa, bb, sq;
  logic [31:0]         den;
  logic signed [31:0]  zang;
  logic signed [15:0]  acc_sat;
  logic                zero_now;
  logic signed [31:0]  zr;
  logic signed [20:0]  pal;
  logic signed [15:0]  ax_line [1:ST_SINCOS];
  logic signed [15:0]  ay_line [1:ST_SINCOS];
  logic signed [15:0]  accel_x_d, accel_y_d;

  // Global advance: hold everything while a result is stalled
  assign en       = !(vld[ST_OUT] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[ST_OUT];

  // Configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PITCH_OFFSET) ? 32'(pitch_offset) : 32'(yaw_offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_offset   <= '0;
      pitch_offset <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_YAW_OFFSET) yaw_offset <= pwdata[15:0];
      else pitch_offset <= pwdata[15:0];
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ST_OUT-1:1], in_valid};
    end
  end

  gfo_sincos u_sc_gy (.clk, .en, .angle(gimbal_yaw_angle), .sin_q24(sgy), .cos_q24(cgy));
  gfo_sincos u_sc_cr (.clk, .en, .angle(chassis_roll_angle), .sin_q24(scr), .cos_q24(ccr));
  gfo_sincos u_sc_cp (.clk, .en, .angle(chassis_pitch_angle), .sin_q24(scp), .cos_q24(ccp));

  // Mix stage values from the product registers
  assign num_full = (m1 + m2) >>> 24;
  assign a_full   = m3 >>> 24;
  assign b_full   = m4 >>> 24;
  assign acc_full = (m5 + m6 + (64'sd1 <<< 23)) >>> 24;
  assign acc_sat  = (acc_full > 64'sd32767) ? 16'sh7fff :
                    (acc_full < -64'sd32768) ? 16'sh8000 : acc_full[15:0];
  assign zero_now = (num_full == 0) && (a_full == 0) && (b_full == 0);

  always_ff @(posedge clk) begin
    if (en) begin
      // Products of sines, cosines and the acceleration inputs
      m1 <= 64'(cgy) * 64'(scp);
      m2 <= 64'(sgy) * 64'(scr);
      m3 <= 64'(sgy) * 64'(ccr);
      m4 <= 64'(cgy) * 64'(ccp);
      m5 <= 64'(accel_x_d) * 64'(sgy);
      m6 <= 64'(accel_y_d) * 64'(cgy);
      // Back to Q24
      a_q <= a_full[31:0];
      b_q <= b_full[31:0];
      // Squares, then their sum
      aa <= 64'(a_q) * 64'(a_q);
      bb <= 64'(b_q) * 64'(b_q);
      sq <= aa + bb;
    end
  end

  // Delay the acceleration inputs to the product stage
  assign accel_x_d = ax_line[ST_SINCOS];
  assign accel_y_d = ay_line[ST_SINCOS];

  always_ff @(posedge clk) begin
    if (en) begin
      ax_line[1] <= accel_x;
      ay_line[1] <= accel_y;
      for (int k = 2; k <= ST_SINCOS; k++) begin
        ax_line[k] <= ax_line[k-1];
        ay_line[k] <= ay_line[k-1];
      end
    end
  end

  // Side data: pitch, field yaw, then acceleration and numerator
  always_ff @(posedge clk) begin
    if (en) begin
      side[1].gp   <= gimbal_pitch_angle;
      side[1].fy   <= wrap_q13(19'(gimbal_yaw_angle) + 19'(chassis_yaw_angle)
                               - 19'(yaw_offset));
      side[1].acc  <= '0;
      side[1].num  <= '0;
      side[1].zero <= 1'b0;
      for (int k = 2; k <= ST_ATAN; k++) begin
        if (k == ST_MIX) begin
          side[k].gp   <= side[k-1].gp;
          side[k].fy   <= side[k-1].fy;
          side[k].acc  <= acc_sat;
          side[k].num  <= num_full[31:0];
          side[k].zero <= zero_now;
        end else begin
          side[k] <= side[k-1];
        end
      end
    end
  end

  gfo_isqrt u_sqrt (.clk, .en, .radicand(sq), .root(den));

  gfo_atan2 u_atan (
    .clk, .en,
    .xin(40'(signed'({1'b0, den}))),
    .yin(40'(side[ST_SQRT].num)),
    .angle(zang)
  );

  // Round, clamp and wrap into the output register
  assign zr  = (zang + 32'sd1024) >>> 11;
  assign pal = side[ST_ATAN].zero ? 21'sd0 :
               (zr > 32'(PITCH_LIMIT)) ? PITCH_LIMIT :
               (zr < -32'(PITCH_LIMIT)) ? -PITCH_LIMIT : zr[20:0];

  always_ff @(posedge clk) begin
    if (en) begin
      field_yaw   <= side[ST_ATAN].fy;
      field_pitch <= wrap_q13(19'(side[ST_ATAN].gp) + 19'(pal) - 19'(pitch_offset));
      chassis_pitch_along_gimbal <= pal[14:0];
      accel_along_gimbal <= side[ST_ATAN].acc;
    end
  end

endmodule

// ----- hw/rtl/gfo_sincos.sv -----
// ----------------------------------------------------------------------------
// gfo_sincos
// Pipelined CORDIC sine and cosine: one reduction stage, one rotation a stage.
// ----------------------------------------------------------------------------
module gfo_sincos (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  output logic signed [31:0] sin_q24,
  output logic signed [31:0] cos_q24
);
  import gfo_pkg::*;

  logic signed [31:0] x [0:CORDIC_STEPS];
  logic signed [31:0] y [0:CORDIC_STEPS];
  logic signed [31:0] z [0:CORDIC_STEPS];
  logic               flip [0:CORDIC_STEPS];
  logic signed [31:0] za;

  assign za = {{5{angle[15]}}, angle, 11'b0};

  // Reduce by pi once, then rotate one step a stage
  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= GAIN_Q24;
      y[0] <= '0;
      if (za > HALF_PI_Q24) begin
        z[0] <= za - PI_Q24;
        flip[0] <= 1'b1;
      end else if (za < -HALF_PI_Q24) begin
        z[0] <= za + PI_Q24;
        flip[0] <= 1'b1;
      end else begin
        z[0] <= za;
        flip[0] <= 1'b0;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        flip[i+1] <= flip[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_q24(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_q24(i);
        end
      end
    end
  end

  assign sin_q24 = flip[CORDIC_STEPS] ? -y[CORDIC_STEPS] : y[CORDIC_STEPS];
  assign cos_q24 = flip[CORDIC_STEPS] ? -x[CORDIC_STEPS] : x[CORDIC_STEPS];

endmodule

// ----- hw/rtl/gfo_isqrt.sv -----
// ----------------------------------------------------------------------------
// gfo_isqrt
// Pipelined floor integer square root of a 64-bit value, one bit pair a stage.
// ----------------------------------------------------------------------------
module gfo_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);
  import gfo_pkg::*;

  logic [63:0] v [1:SQRT_STEPS];
  logic [63:0] r [1:SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] TRIAL = 64'd1 << (62 - 2 * k);
    logic [63:0] vi;
    logic [63:0] ri;

    if (k == 0) begin : g_first
      assign vi = radicand;
      assign ri = '0;
    end else begin : g_rest
      assign vi = v[k];
      assign ri = r[k];
    end

    // Try one root bit a stage, from the top
    always_ff @(posedge clk) begin
      if (en) begin
        if (vi >= ri + TRIAL) begin
          v[k+1] <= vi - (ri + TRIAL);
          r[k+1] <= (ri >> 1) + TRIAL;
        end else begin
          v[k+1] <= vi;
          r[k+1] <= ri >> 1;
        end
      end
    end
  end

  assign root = r[SQRT_STEPS][31:0];

endmodule

// ----- hw/rtl/gfo_atan2.sv -----
// ----------------------------------------------------------------------------
// gfo_atan2
// Pipelined CORDIC vectoring for atan2 with a non-negative x, Q24 angle out.
// ----------------------------------------------------------------------------
module gfo_atan2 (
  input  logic               clk,
  input  logic               en,
  input  logic signed [39:0] xin,
  input  logic signed [39:0] yin,
  output logic signed [31:0] angle
);
  import gfo_pkg::*;

  logic signed [39:0] x [1:CORDIC_STEPS];
  logic signed [39:0] y [1:CORDIC_STEPS];
  logic signed [31:0] z [1:CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [39:0] xi;
    logic signed [39:0] yi;
    logic signed [31:0] zi;

    if (i == 0) begin : g_first
      assign xi = xin;
      assign yi = yin;
      assign zi = '0;
    end else begin : g_rest
      assign xi = x[i];
      assign yi = y[i];
      assign zi = z[i];
    end

    // Drive y toward zero one step a stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (yi > 0) begin
          x[i+1] <= xi + (yi >>> i);
          y[i+1] <= yi - (xi >>> i);
          z[i+1] <= zi + atan_q24(i);
        end else begin
          x[i+1] <= xi - (yi >>> i);
          y[i+1] <= yi + (xi >>> i);
          z[i+1] <= zi - atan_q24(i);
        end
      end
    end
  end

  assign angle = z[CORDIC_STEPS];

endmodule
